>>> hw/rtl/albe_pkg.sv
// Package for the addressable LED bit encoder.
// Holds word types, register indexes, channel order codes and sequencer states.
// No dependencies.
package albe_pkg;

   // Field widths
   localparam int COLOR_W       = 8;
   localparam int PIXEL_W       = 3 * COLOR_W;
   localparam int CYCLE_W       = 20;
   localparam int BIT_COUNT_W   = 5;
   localparam int CSR_INDEX_W   = 3;
   localparam int TIMER_WIDTH_DEFAULT = 20;

   localparam logic [BIT_COUNT_W-1:0] LAST_BIT = BIT_COUNT_W'(PIXEL_W - 1);

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CHANNEL_ORDER      = 3'd0,
      REG_INVERTED_POLARITY  = 3'd1,
      REG_ONE_FIRST_CYCLES   = 3'd2,
      REG_ONE_SECOND_CYCLES  = 3'd3,
      REG_ZERO_FIRST_CYCLES  = 3'd4,
      REG_ZERO_SECOND_CYCLES = 3'd5,
      REG_LATCH_CYCLES       = 3'd6
   } csr_index_type;

   // Transmit channel order; the unused code sends green-red-blue
   typedef enum logic [1:0] {
      ORDER_GRB = 2'd0,
      ORDER_RGB = 2'd1,
      ORDER_RBG = 2'd2
   } channel_order_type;

   // Segment sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BITS,
      ST_LATCH
   } enc_state_type;

   // Input word: one pixel
   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               frame_end;
   } req_word_type;

   // Output word: one line segment
   typedef struct packed {
      logic               line_level;
      logic [CYCLE_W-1:0] segment_cycles;
      logic               is_latch;
      logic               run_last;
   } rsp_word_type;

endpackage

>>> hw/rtl/addressable_led_bit_encoder_top.sv
// Addressable LED bit encoder, top level.
// Turns pixels into one-wire line segments (level plus hold time).
// Depends on albe_pkg.
//
//   channel | ports                                   | word
//   --------+-----------------------------------------+----------------------
//   req     | req_valid, req_ready, req_data          | req_word_type (pixel)
//   rsp     | rsp_valid, rsp_ready, rsp_data          | rsp_word_type (segment)
//   csr     | csr_we, csr_index, csr_wdata            | 20-bit register value
//
// One segment leaves per cycle from the color shift register unless rsp stalls,
// one bit shifted every two segments: a pixel makes 48 segments, 49 with a latch.
// The next pixel is taken in the cycle its predecessor's final segment is made.
// Synchronous reset clears the sequencer and loads the default timings.
// A stalled rsp holds the output register and freezes the shift register.
module addressable_led_bit_encoder_top
   import albe_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CYCLE_W-1:0]     csr_wdata
);

   // Timer bits kept per timing register
   localparam int HOLD_W = (TIMER_WIDTH < CYCLE_W) ? TIMER_WIDTH : CYCLE_W;

   // Configuration registers
   logic [1:0]        channel_order_ff;
   logic              inverted_polarity_ff;
   logic [HOLD_W-1:0] one_first_ff;
   logic [HOLD_W-1:0] one_second_ff;
   logic [HOLD_W-1:0] zero_first_ff;
   logic [HOLD_W-1:0] zero_second_ff;
   logic [HOLD_W-1:0] latch_ff;

   // Sequencer and shift state
   enc_state_type          state_ff, state_in;
   logic [PIXEL_W-1:0]     color_shift_ff, color_shift_in;
   logic [BIT_COUNT_W-1:0] bit_count_ff, bit_count_in;
   logic                   second_phase_ff, second_phase_in;
   logic                   latch_pending_ff, latch_pending_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_data_ff;

   logic               req_fire;
   logic               seg_fire;
   logic               seg_active;
   rsp_word_type       seg_word;
   logic [HOLD_W-1:0]  seg_time;
   logic [PIXEL_W-1:0] packed_color;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_order_ff     <= ORDER_GRB;
         inverted_polarity_ff <= 1'b0;
         one_first_ff         <= HOLD_W'(70);
         one_second_ff        <= HOLD_W'(60);
         zero_first_ff        <= HOLD_W'(35);
         zero_second_ff       <= HOLD_W'(80);
         latch_ff             <= HOLD_W'(5000);
      end else if (csr_we) begin
         case (csr_index)
            REG_CHANNEL_ORDER:      channel_order_ff     <= csr_wdata[1:0];
            REG_INVERTED_POLARITY:  inverted_polarity_ff <= csr_wdata[0];
            REG_ONE_FIRST_CYCLES:   one_first_ff         <= csr_wdata[HOLD_W-1:0];
            REG_ONE_SECOND_CYCLES:  one_second_ff        <= csr_wdata[HOLD_W-1:0];
            REG_ZERO_FIRST_CYCLES:  zero_first_ff        <= csr_wdata[HOLD_W-1:0];
            REG_ZERO_SECOND_CYCLES: zero_second_ff       <= csr_wdata[HOLD_W-1:0];
            REG_LATCH_CYCLES:       latch_ff             <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // Pack the pixel in transmit order
   always_comb begin
      case (channel_order_ff)
         ORDER_RGB: packed_color = {req_data.red, req_data.green, req_data.blue};
         ORDER_RBG: packed_color = {req_data.red, req_data.blue, req_data.green};
         default:   packed_color = {req_data.green, req_data.red, req_data.blue};
      endcase
   end

   // Build the segment for the current state
   always_comb begin
      seg_active = 1'b0;
      seg_time   = latch_ff;
      seg_word   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            seg_active = 1'b0;
         end
         ST_BITS: begin
            seg_active = 1'b1;
            if (!second_phase_ff) begin
               seg_time = color_shift_ff[PIXEL_W-1] ? one_first_ff : zero_first_ff;
               seg_word.line_level = ~inverted_polarity_ff;
            end else begin
               seg_time = color_shift_ff[PIXEL_W-1] ? one_second_ff : zero_second_ff;
               seg_word.line_level = inverted_polarity_ff;
               seg_word.run_last   = (bit_count_ff == LAST_BIT) && !latch_pending_ff;
            end
         end
         ST_LATCH: begin
            seg_active          = 1'b1;
            seg_time            = latch_ff;
            seg_word.line_level = inverted_polarity_ff;
            seg_word.is_latch   = 1'b1;
            seg_word.run_last   = 1'b1;
         end
         default: begin
            seg_active = 1'b0;
         end
      endcase
      // A zero hold time goes out as one cycle
      seg_word.segment_cycles = (seg_time == '0) ? CYCLE_W'(1) : CYCLE_W'(seg_time);
   end

   // Handshakes: make a segment when the output register frees up
   assign seg_fire  = seg_active && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || (seg_fire && seg_word.run_last);
   assign req_fire  = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_BITS;
         end
         ST_BITS: begin
            if (seg_fire && second_phase_ff && bit_count_ff == LAST_BIT) begin
               if (latch_pending_ff) state_in = ST_LATCH;
               else if (req_fire)    state_in = ST_BITS;
               else                  state_in = ST_IDLE;
            end
         end
         ST_LATCH: begin
            if (seg_fire) state_in = req_fire ? ST_BITS : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Advance the shift register, bit count and phase
   always_comb begin
      color_shift_in   = color_shift_ff;
      bit_count_in     = bit_count_ff;
      second_phase_in  = second_phase_ff;
      latch_pending_in = latch_pending_ff;
      if (req_fire) begin
         color_shift_in   = packed_color;
         bit_count_in     = '0;
         second_phase_in  = 1'b0;
         latch_pending_in = req_data.frame_end;
      end else if (seg_fire && state_ff == ST_BITS) begin
         second_phase_in = ~second_phase_ff;
         if (second_phase_ff) begin
            color_shift_in = {color_shift_ff[PIXEL_W-2:0], 1'b0};
            bit_count_in   = bit_count_ff + 1'b1;
         end
      end else if (seg_fire && state_ff == ST_LATCH) begin
         latch_pending_in = 1'b0;
      end
   end

   // Hold a segment until taken
   always_comb begin
      if (seg_fire)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         bit_count_ff     <= '0;
         second_phase_ff  <= 1'b0;
         latch_pending_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         bit_count_ff     <= bit_count_in;
         second_phase_ff  <= second_phase_in;
         latch_pending_ff <= latch_pending_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      color_shift_ff <= color_shift_in;
      if (seg_fire) rsp_data_ff <= seg_word;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/sv/addressable_led_bit_encoder_checker.sv
// Checker for the addressable LED bit encoder: watches the pixel, segment and
// register ports, predicts the segment words and compares them in order.
// Depends on albe_pkg.
`timescale 1ns / 1ps

module addressable_led_bit_encoder_checker
   import albe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_word_type           req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_word_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CYCLE_W-1:0]     csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   // Shadow copy of the encoder registers
   logic [1:0]         order_reg;
   logic               polarity_reg;
   logic [CYCLE_W-1:0] one_first_reg;
   logic [CYCLE_W-1:0] one_second_reg;
   logic [CYCLE_W-1:0] zero_first_reg;
   logic [CYCLE_W-1:0] zero_second_reg;
   logic [CYCLE_W-1:0] latch_reg;

   rsp_word_type       expected_segments[$];
   rsp_word_type       want;
   int                 segment_count;

   // A hold time of zero goes out as one cycle
   function automatic logic [CYCLE_W-1:0] hold_cycles(input logic [CYCLE_W-1:0] value);
      return (value == '0) ? CYCLE_W'(1) : value;
   endfunction

   task automatic report_failure(input string msg);
      $display("%0t ns: segment %0d: %s", $time, segment_count, msg);
      fail_count++;
   endtask

   // Expand one pixel into its bit segments, plus the latch at frame end
   task automatic encode_pixel(input req_word_type pix);
      logic [PIXEL_W-1:0] color_bits;
      logic               first_level;
      rsp_word_type       seg;
      case (order_reg)
         ORDER_RGB: color_bits = {pix.red, pix.green, pix.blue};
         ORDER_RBG: color_bits = {pix.red, pix.blue, pix.green};
         default:   color_bits = {pix.green, pix.red, pix.blue};
      endcase
      first_level = ~polarity_reg;
      for (int i = PIXEL_W - 1; i >= 0; i--) begin
         seg.line_level     = first_level;
         seg.segment_cycles = hold_cycles(color_bits[i] ? one_first_reg : zero_first_reg);
         seg.is_latch       = 1'b0;
         seg.run_last       = 1'b0;
         expected_segments.push_back(seg);
         seg.line_level     = ~first_level;
         seg.segment_cycles = hold_cycles(color_bits[i] ? one_second_reg : zero_second_reg);
         seg.run_last       = (i == 0) && !pix.frame_end;
         expected_segments.push_back(seg);
      end
      if (pix.frame_end) begin
         seg.line_level     = ~first_level;
         seg.segment_cycles = hold_cycles(latch_reg);
         seg.is_latch       = 1'b1;
         seg.run_last       = 1'b1;
         expected_segments.push_back(seg);
      end
   endtask

   // Compare accepted segments first, then predict from the accepted pixel
   always @(posedge clock) begin
      if (reset) begin
         order_reg       <= 2'd0;
         polarity_reg    <= 1'b0;
         one_first_reg   <= CYCLE_W'(70);
         one_second_reg  <= CYCLE_W'(60);
         zero_first_reg  <= CYCLE_W'(35);
         zero_second_reg <= CYCLE_W'(80);
         latch_reg       <= CYCLE_W'(5000);
         expected_segments.delete();
         segment_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_segments.size() == 0) begin
               report_failure($sformatf("unexpected word 0x%0h", rsp_data));
            end else begin
               want = expected_segments.pop_front();
               if (rsp_data.line_level !== want.line_level)
                  report_failure($sformatf("line_level %0b, expected %0b",
                                           rsp_data.line_level, want.line_level));
               if (rsp_data.segment_cycles !== want.segment_cycles)
                  report_failure($sformatf("segment_cycles %0d, expected %0d",
                                           rsp_data.segment_cycles, want.segment_cycles));
               if (rsp_data.is_latch !== want.is_latch)
                  report_failure($sformatf("is_latch %0b, expected %0b",
                                           rsp_data.is_latch, want.is_latch));
               if (rsp_data.run_last !== want.run_last)
                  report_failure($sformatf("run_last %0b, expected %0b",
                                           rsp_data.run_last, want.run_last));
            end
            segment_count++;
         end
         if (req_valid && req_ready)
            encode_pixel(req_data);
         // Track register writes; unknown indexes are dropped
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_CHANNEL_ORDER:      order_reg       <= csr_wdata[1:0];
               REG_INVERTED_POLARITY:  polarity_reg    <= csr_wdata[0];
               REG_ONE_FIRST_CYCLES:   one_first_reg   <= csr_wdata;
               REG_ONE_SECOND_CYCLES:  one_second_reg  <= csr_wdata;
               REG_ZERO_FIRST_CYCLES:  zero_first_reg  <= csr_wdata;
               REG_ZERO_SECOND_CYCLES: zero_second_reg <= csr_wdata;
               REG_LATCH_CYCLES:       latch_reg       <= csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = expected_segments.size();
   end

endmodule

>>> tb/sv/addressable_led_bit_encoder_top_tb.sv
// Testbench top for the addressable LED bit encoder: clock, reset, pixel and
// register stimulus, segment back-pressure and the final verdict.
// Depends on albe_pkg, addressable_led_bit_encoder_top and the checker.
`timescale 1ns / 1ps

module addressable_led_bit_encoder_top_tb;
   import albe_pkg::*;

   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 64;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PHASE_ITEMS   = 21;
   localparam int PHASE_COUNT   = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE   = 3'd7;
   localparam logic [1:0]             ORDER_SPARE = 2'd3;
   localparam logic [CYCLE_W-1:0]     CYCLES_MAX  = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CYCLE_W-1:0]     csr_wdata = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cycle_count   = 0;
   int check_failures;
   int segments_owed;

   addressable_led_bit_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   addressable_led_bit_encoder_checker segment_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (check_failures),
      .pending_count (segments_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the segment side at the phase's rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [COLOR_W-1:0] random_color();
      if ($urandom_range(3) == 0)
         return $urandom_range(1) ? 8'hFF : 8'h00;
      return COLOR_W'($urandom);
   endfunction

   function automatic req_word_type random_pixel();
      req_word_type pix;
      pix.red       = random_color();
      pix.green     = random_color();
      pix.blue      = random_color();
      pix.frame_end = ($urandom_range(3) == 0);
      return pix;
   endfunction

   // Favor the zero, one-cycle and full-scale timings
   function automatic logic [CYCLE_W-1:0] random_timing();
      case ($urandom_range(5))
         0:       return '0;
         1:       return CYCLE_W'(1);
         2:       return CYCLES_MAX;
         default: return CYCLE_W'($urandom);
      endcase
   endfunction

   // Hold valid across back-to-back words; drop it only for an idle gap
   task automatic send_pixel(input req_word_type pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CYCLE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Drain the encoder, then load a full register set
   task automatic apply_settings(input logic [1:0] order, input logic polarity,
                                 input logic [CYCLE_W-1:0] one_first,
                                 input logic [CYCLE_W-1:0] one_second,
                                 input logic [CYCLE_W-1:0] zero_first,
                                 input logic [CYCLE_W-1:0] zero_second,
                                 input logic [CYCLE_W-1:0] latch_len);
      req_valid <= 1'b0;
      // Let the checker count the last accepted pixel before polling
      @(posedge clock);
      while (segments_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_CHANNEL_ORDER, {(CYCLE_W-2)'($urandom), order});
      write_reg(REG_INVERTED_POLARITY, {(CYCLE_W-1)'($urandom), polarity});
      write_reg(REG_ONE_FIRST_CYCLES, one_first);
      write_reg(REG_ONE_SECOND_CYCLES, one_second);
      write_reg(REG_ZERO_FIRST_CYCLES, zero_first);
      write_reg(REG_ZERO_SECOND_CYCLES, zero_second);
      write_reg(REG_LATCH_CYCLES, latch_len);
      write_reg(REG_SPARE, CYCLE_W'($urandom));
      csr_we <= 1'b0;
   endtask

   // Distinct channel bytes so a swapped order shows up
   task automatic send_order_probes();
      send_pixel(req_word_type'({8'h81, 8'h42, 8'h3C, 1'b0}));
      send_pixel(req_word_type'({8'hA5, 8'h5A, 8'hC3, 1'b1}));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset timings, then every channel order and both polarities
      send_pixel(req_word_type'({8'h00, 8'h00, 8'h00, 1'b0}));
      send_pixel(req_word_type'({8'hFF, 8'hFF, 8'hFF, 1'b1}));
      send_pixel(req_word_type'({8'h81, 8'h42, 8'h3C, 1'b0}));
      send_pixel(req_word_type'({8'h01, 8'h80, 8'h7E, 1'b1}));
      apply_settings(ORDER_GRB, 1'b0, CYCLES_MAX, CYCLE_W'(1), '0, CYCLE_W'(20'h80000),
                     CYCLE_W'(1));
      send_order_probes();
      apply_settings(ORDER_RGB, 1'b1, CYCLE_W'(2), '0, CYCLES_MAX, CYCLE_W'(5), '0);
      send_order_probes();
      apply_settings(ORDER_RBG, 1'b0, '0, CYCLE_W'(20'hFFFFE), CYCLE_W'(7), CYCLES_MAX,
                     CYCLES_MAX);
      send_order_probes();
      apply_settings(ORDER_SPARE, 1'b1, CYCLE_W'(13), CYCLE_W'(14), CYCLE_W'(15),
                     CYCLE_W'(16), CYCLE_W'(17));
      send_order_probes();

      // Random: two register sets per idling mode
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         apply_settings(2'($urandom_range(3)), 1'($urandom_range(1)), random_timing(),
                        random_timing(), random_timing(), random_timing(),
                        random_timing());
         case (phase / 2)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         repeat (PHASE_ITEMS) send_pixel(random_pixel());
      end

      // Drain and give stray words time to show up
      req_valid <= 1'b0;
      @(posedge clock);
      while (segments_owed != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (check_failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
